### sv/mexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
// Holds the controller state encoding, the command and status bundles, and defaults.
// No dependencies.
`default_nettype none

package mexp_pkg;

   // Fixed port widths.
   localparam int DATA_WIDTH = 32;

   // Defaults for the top-level parameters.
   localparam int EXP_WIDTH_DEFAULT = 32;
   localparam int MOD_WIDTH_DEFAULT = 32;

   // Modulus register value after reset.
   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_CHECK,
      ST_RED,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // Latch exponent, set accumulator to one, start base reduction.
      logic take_base;   // Running base takes the reduced input base.
      logic mult;        // Start both products and their reductions.
      logic step;        // Commit reduced products and shift the exponent.
      logic write_out;   // Load the result register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic red_busy;    // Reduction still running.
      logic exp_zero;    // No set exponent bits remain.
      logic mod_small;   // Modulus is zero or one.
   } status_type;

endpackage

`default_nettype wire

### sv/mexp_modred.sv
// Bit-serial modular reducer: one dividend bit per cycle, restoring compare and subtract.
// Used by the modular exponentiation datapath. Depends on nothing but its parameters.
`default_nettype none

module mexp_modred #(
   parameter int MOD_WIDTH = 32,
   parameter int RED_WIDTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [RED_WIDTH-1:0] value,
   input  wire logic [MOD_WIDTH-1:0] modulus,
   output logic                      busy,
   output logic [MOD_WIDTH-1:0]      remainder
);

   localparam int CNT_WIDTH = $clog2(RED_WIDTH + 1);

   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic [RED_WIDTH-1:0] shift_ff, shift_in;
   logic [MOD_WIDTH-1:0] rem_ff, rem_in;

   logic [MOD_WIDTH:0]   trial;
   logic [MOD_WIDTH:0]   diff;

   // Partial remainder with the next dividend bit shifted in, and its trial subtraction.
   assign trial = {rem_ff, shift_ff[RED_WIDTH-1]};
   assign diff  = trial - {1'b0, modulus};

   // Next-state logic for the shift register, remainder and bit counter.
   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CNT_WIDTH'(RED_WIDTH);
         shift_in = value;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[RED_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = diff[MOD_WIDTH-1:0];
         end else begin
            rem_in = trial[MOD_WIDTH-1:0];
         end
      end
   end

   // The counter is control state; the data registers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy      = (count_ff != '0);
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### sv/mexp_ctrl.sv
// Controller state machine for the modular exponentiation core.
// Sequences base reduction, square-and-multiply rounds and result handoff. Uses mexp_pkg.
`default_nettype none

module mexp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire mexp_pkg::status_type status,
   output mexp_pkg::cmd_type         cmd
);

   mexp_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State register and result-valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.mod_small ? mexp_pkg::ST_DONE : mexp_pkg::ST_BASE;
            end
         end
         mexp_pkg::ST_BASE: begin
            if (!status.red_busy) begin
               cmd.take_base = 1'b1;
               state_in      = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = mexp_pkg::ST_DONE;
            end else begin
               cmd.mult = 1'b1;
               state_in = mexp_pkg::ST_RED;
            end
         end
         mexp_pkg::ST_RED: begin
            if (!status.red_busy) begin
               cmd.step = 1'b1;
               state_in = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_DONE: begin
            // Hand off once the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.write_out = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = mexp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/mexp_dp.sv
// Datapath for the modular exponentiation core: modulus register, operand registers,
// two multipliers with serial reducers, and the result register. Uses mexp_pkg, mexp_modred.
`default_nettype none

module mexp_dp #(
   parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT,
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] csr_write_data,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_base_value,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_exponent,
   input  wire mexp_pkg::cmd_type               cmd,
   output mexp_pkg::status_type                 status,
   output logic [mexp_pkg::DATA_WIDTH-1:0]      rsp_power_residue
);

   // Only exponent bits that exist on the port can be set.
   localparam int EXP_USED  = (EXP_WIDTH < mexp_pkg::DATA_WIDTH) ? EXP_WIDTH
                                                                 : mexp_pkg::DATA_WIDTH;
   // Dividend width must hold a full product and the raw input base.
   localparam int RED_WIDTH = (2 * MOD_WIDTH > mexp_pkg::DATA_WIDTH) ? 2 * MOD_WIDTH
                                                                     : mexp_pkg::DATA_WIDTH;

   logic [MOD_WIDTH-1:0]            modulus_ff, modulus_in;
   logic [EXP_USED-1:0]             exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]            acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]            run_ff, run_in;
   logic [mexp_pkg::DATA_WIDTH-1:0] out_ff, out_in;

   logic [2*MOD_WIDTH-1:0]          prod_mul;
   logic [2*MOD_WIDTH-1:0]          prod_sq;
   logic [RED_WIDTH-1:0]            red_a_value;
   logic                            red_a_busy;
   logic                            red_b_busy;
   logic [MOD_WIDTH-1:0]            red_a_rem;
   logic [MOD_WIDTH-1:0]            red_b_rem;
   logic                            mod_small;

   // Modulus register; write it only while the core is idle (not enforced by the block).
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write_enable) begin
         modulus_in = csr_write_data[MOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
      end else begin
         modulus_ff <= modulus_in;
      end
   end

   assign mod_small = (modulus_ff[MOD_WIDTH-1:1] == '0);

   // Both products come from the current operands; the reducers register them.
   assign prod_mul    = acc_ff * run_ff;
   assign prod_sq     = run_ff * run_ff;
   assign red_a_value = cmd.load ? RED_WIDTH'(req_base_value) : RED_WIDTH'(prod_mul);

   mexp_modred #(
      .MOD_WIDTH (MOD_WIDTH),
      .RED_WIDTH (RED_WIDTH)
   ) u_red_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load | cmd.mult),
      .value     (red_a_value),
      .modulus   (modulus_ff),
      .busy      (red_a_busy),
      .remainder (red_a_rem)
   );

   mexp_modred #(
      .MOD_WIDTH (MOD_WIDTH),
      .RED_WIDTH (RED_WIDTH)
   ) u_red_sq (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mult),
      .value     (RED_WIDTH'(prod_sq)),
      .modulus   (modulus_ff),
      .busy      (red_b_busy),
      .remainder (red_b_rem)
   );

   // Operand, exponent and result register updates.
   always_comb begin
      exp_in = exp_ff;
      acc_in = acc_ff;
      run_in = run_ff;
      out_in = out_ff;
      if (cmd.load) begin
         exp_in = req_exponent[EXP_USED-1:0];
         acc_in = MOD_WIDTH'(1);
      end
      if (cmd.take_base) begin
         run_in = red_a_rem;
      end
      if (cmd.step) begin
         if (exp_ff[0]) begin
            acc_in = red_a_rem;
         end
         run_in = red_b_rem;
         exp_in = exp_ff >> 1;
      end
      if (cmd.write_out) begin
         out_in = mod_small ? '0 : mexp_pkg::DATA_WIDTH'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      acc_ff <= acc_in;
      run_ff <= run_in;
      out_ff <= out_in;
   end

   assign status.red_busy  = red_a_busy | red_b_busy;
   assign status.exp_zero  = (exp_ff == '0);
   assign status.mod_small = mod_small;

   assign rsp_power_residue = out_ff;

endmodule

`default_nettype wire

### sv/modular_exponentiation_core.sv
// Top level of the modular exponentiation core (right-to-left square and multiply).
// Joins the controller and the datapath. Uses mexp_pkg, mexp_ctrl, mexp_dp.
//
//   Channel  Ports                                  Direction  Handshake
//   req      req_base_value, req_exponent           in         req_valid / req_ready
//   rsp      rsp_power_residue                      out        rsp_valid / rsp_ready
//   csr      csr_write_data (modulus)               in         csr_write_enable, no wait
//
// One transaction at a time. A transaction reduces the base and then runs one round per
// exponent bit up to the highest set one; its length is set by the bit-serial reducers
// (one dividend bit per cycle). A modulus of zero or one skips the work and answers zero.
// A finished result waits in the output register while the next transaction is accepted.
// Reset is synchronous and active high; it restores the modulus to 1000000007.
`default_nettype none

module modular_exponentiation_core #(
   parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEFAULT,
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_base_value,
   input  wire logic [mexp_pkg::DATA_WIDTH-1:0] req_exponent,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [mexp_pkg::DATA_WIDTH-1:0]      rsp_power_residue
);

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   // Sequencing.
   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and storage.
   mexp_dp #(
      .EXP_WIDTH (EXP_WIDTH),
      .MOD_WIDTH (MOD_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_base_value    (req_base_value),
      .req_exponent      (req_exponent),
      .cmd               (cmd),
      .status            (status),
      .rsp_power_residue (rsp_power_residue)
   );

endmodule

`default_nettype wire

### sv/mexp_checker.sv
// Port-level assertions for the modular exponentiation core, bound to the top level.
// Uses mexp_pkg for widths and the modulus reset value.
`default_nettype none

module mexp_checker #(
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEFAULT
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            csr_write_enable,
   input wire logic [mexp_pkg::DATA_WIDTH-1:0] csr_write_data,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mexp_pkg::DATA_WIDTH-1:0] rsp_power_residue
);

   logic mod_small_ff, mod_small_in;

   // Tracks whether the effective modulus is zero or one.
   always_comb begin
      mod_small_in = mod_small_ff;
      if (csr_write_enable) begin
         mod_small_in = (csr_write_data[MOD_WIDTH-1:1] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_small_ff <= (mexp_pkg::MODULUS_RESET[MOD_WIDTH-1:1] == '0);
      end else begin
         mod_small_ff <= mod_small_in;
      end
   end

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power_residue))
      else $error("stalled result changed");

   // One transaction at a time: the input closes right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input stayed open after a transaction");

   // A modulus of zero or one always yields zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mod_small_ff |-> rsp_power_residue == '0)
      else $error("nonzero result for modulus zero or one");

endmodule

bind modular_exponentiation_core mexp_checker #(
   .MOD_WIDTH (MOD_WIDTH)
) u_mexp_checker (
   .clock             (clock),
   .reset             (reset),
   .csr_write_enable  (csr_write_enable),
   .csr_write_data    (csr_write_data),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_power_residue (rsp_power_residue)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for modular_exponentiation_core with default parameters.
// Runs a directed table and then random items under several modulus settings, with
// random sender bursts and receiver stalls. Depends on mexp_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int LONG_HOLD_CYCLES = 8000;
   localparam int END_SETTLE_CYCLES = 2500;

   // One row of the directed table. The residue is used only where known is set.
   typedef struct packed {
      logic [mexp_pkg::DATA_WIDTH-1:0] modulus;
      logic [mexp_pkg::DATA_WIDTH-1:0] base;
      logic [mexp_pkg::DATA_WIDTH-1:0] exponent;
      logic                            known;
      logic [mexp_pkg::DATA_WIDTH-1:0] residue;
   } directed_case_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [mexp_pkg::DATA_WIDTH-1:0] csr_write_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [mexp_pkg::DATA_WIDTH-1:0] req_base_value = '0;
   logic [mexp_pkg::DATA_WIDTH-1:0] req_exponent = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mexp_pkg::DATA_WIDTH-1:0] rsp_power_residue;

   // Modulus as the block should hold it, and the residues still owed by the block.
   logic [mexp_pkg::DATA_WIDTH-1:0] modulus_setting = mexp_pkg::MODULUS_RESET;
   logic [mexp_pkg::DATA_WIDTH-1:0] pending_residues[$];

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned residues_checked = 0;
   int unsigned settings_used = 1;
   int          burst_left = 0;
   bit          long_hold_request = 1'b0;

   directed_case_type directed_cases [DIRECTED_COUNT] = '{
      // Reset modulus: zero power, small powers, field extremes, bases at the modulus.
      '{mexp_pkg::MODULUS_RESET, 32'd0, 32'd0, 1'b1, 32'd1},
      '{mexp_pkg::MODULUS_RESET, 32'd2, 32'd10, 1'b1, 32'd1024},
      '{mexp_pkg::MODULUS_RESET, 32'hFFFFFFFF, 32'd1, 1'b1, 32'd294967267},
      '{mexp_pkg::MODULUS_RESET, 32'd0, 32'hFFFFFFFF, 1'b1, 32'd0},
      '{mexp_pkg::MODULUS_RESET, 32'd1, 32'hFFFFFFFF, 1'b1, 32'd1},
      '{mexp_pkg::MODULUS_RESET, 32'd1000000007, 32'd5, 1'b1, 32'd0},
      '{mexp_pkg::MODULUS_RESET, 32'd1000000006, 32'd2, 1'b1, 32'd1},
      '{mexp_pkg::MODULUS_RESET, 32'd1000000006, 32'd3, 1'b1, 32'd1000000006},
      '{mexp_pkg::MODULUS_RESET, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0},
      '{mexp_pkg::MODULUS_RESET, 32'h12345678, 32'h80000000, 1'b0, 32'd0},
      // Modulus one and modulus zero both answer zero.
      '{32'd1, 32'd123, 32'd0, 1'b1, 32'd0},
      '{32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
      '{32'd0, 32'd5, 32'd7, 1'b1, 32'd0},
      '{32'd0, 32'hFFFFFFFF, 32'd0, 1'b1, 32'd0},
      // Smallest working modulus.
      '{32'd2, 32'd3, 32'd0, 1'b1, 32'd1},
      '{32'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
      '{32'd2, 32'd4, 32'd9, 1'b1, 32'd0},
      // Largest modulus, where the modulus minus one behaves as minus one.
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3, 1'b1, 32'd0},
      '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2, 1'b1, 32'd1},
      '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFE},
      '{32'hFFFFFFFF, 32'd2, 32'd32, 1'b1, 32'd1},
      '{32'hFFFFFFFF, 32'hDEADBEEF, 32'h0001E240, 1'b0, 32'd0},
      // Power of two modulus.
      '{32'h80000000, 32'd2, 32'd31, 1'b1, 32'd0},
      '{32'h80000000, 32'd3, 32'hFFFFFFFF, 1'b0, 32'd0}
   };

   modular_exponentiation_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_power_residue(rsp_power_residue)
   );

   // Free-running clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Cycle counter and the timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles with %0d residues outstanding",
               cycle_count, pending_residues.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // Right-to-left square and multiply, with every product reduced by the modulus.
   function automatic logic [mexp_pkg::DATA_WIDTH-1:0] modexp_residue(
      input logic [mexp_pkg::DATA_WIDTH-1:0] base,
      input logic [mexp_pkg::DATA_WIDTH-1:0] exponent,
      input logic [mexp_pkg::DATA_WIDTH-1:0] modulus
   );
      logic [63:0] wide_modulus;
      logic [63:0] running_base;
      logic [63:0] accumulator;
      wide_modulus = 64'(modulus);
      if (wide_modulus <= 64'd1) begin
         return '0;
      end
      running_base = 64'(base) % wide_modulus;
      accumulator = 64'd1;
      for (int bit_index = 0; bit_index < mexp_pkg::EXP_WIDTH_DEFAULT; bit_index++) begin
         if (exponent[bit_index]) begin
            accumulator = (accumulator * running_base) % wide_modulus;
         end
         running_base = (running_base * running_base) % wide_modulus;
      end
      return accumulator[mexp_pkg::DATA_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string message);
      $display("MISMATCH at cycle %0d: %s", cycle_count, message);
      error_count++;
   endtask

   // Offers one transaction, honoring the burst pattern, and records its residue once accepted.
   task automatic offer_request(
      input logic [mexp_pkg::DATA_WIDTH-1:0] base,
      input logic [mexp_pkg::DATA_WIDTH-1:0] exponent,
      input logic [mexp_pkg::DATA_WIDTH-1:0] residue
   );
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 30);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_base_value <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!req_ready);
      pending_residues = {pending_residues, residue};
      items_sent++;
   endtask

   // Lets the block finish all work, then writes a new modulus.
   task automatic settle_and_write_modulus(input logic [mexp_pkg::DATA_WIDTH-1:0] value);
      req_valid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      modulus_setting = value;
      settings_used++;
   endtask

   // Receiver: switches among stall styles at random, and once holds off for long.
   initial begin : receiver
      int hold_left;
      int pattern_left;
      int stall_mode;
      int stride;
      hold_left = 0;
      pattern_left = 0;
      stall_mode = 0;
      stride = 0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               pattern_left = $urandom_range(20, 300);
            end
            pattern_left--;
            stride++;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= (stride % 5 >= 2);
            endcase
         end
      end
   end

   // Compares each accepted result transaction with the oldest owed residue.
   always @(posedge clock) begin : check_residues
      logic [mexp_pkg::DATA_WIDTH-1:0] expected_value;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_residues.size() == 0) begin
            report_mismatch($sformatf("unexpected result transaction, residue 0x%08h",
                                      rsp_power_residue));
         end else begin
            expected_value = pending_residues.pop_front();
            residues_checked++;
            if (rsp_power_residue !== expected_value) begin
               report_mismatch($sformatf("power_residue 0x%08h, expected 0x%08h",
                                         rsp_power_residue, expected_value));
            end
         end
      end
   end

   // Stimulus: directed table, then random phases under different moduli.
   initial begin : stimulus
      directed_case_type               row;
      logic [mexp_pkg::DATA_WIDTH-1:0] phase_moduli [RANDOM_PHASES];
      logic [mexp_pkg::DATA_WIDTH-1:0] base;
      logic [mexp_pkg::DATA_WIDTH-1:0] exponent;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed rows; a change of modulus waits for the block to go idle.
      for (int row_index = 0; row_index < DIRECTED_COUNT; row_index++) begin
         row = directed_cases[row_index];
         if (row.modulus != modulus_setting) begin
            settle_and_write_modulus(row.modulus);
         end
         offer_request(row.base, row.exponent,
                       row.known ? row.residue
                                 : modexp_residue(row.base, row.exponent, modulus_setting));
      end

      phase_moduli[0] = mexp_pkg::MODULUS_RESET;
      phase_moduli[1] = 32'hFFFFFFFF;
      phase_moduli[2] = $urandom | 32'h80000000;
      phase_moduli[3] = $urandom_range(2, 1000);
      phase_moduli[4] = 32'd1;
      phase_moduli[5] = $urandom;

      // Random items. Most exponents are short to keep the run brief; many use all 32 bits.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_and_write_modulus(phase_moduli[phase]);
         if (phase == 1) begin
            long_hold_request = 1'b1;
         end
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            case ($urandom_range(0, 7))
               0, 1, 2, 3, 4: base = $urandom;
               5: base = modulus_setting - 1;
               6: base = modulus_setting;
               default: base = ($urandom_range(0, 1) != 0) ? modulus_setting + 1 : '1;
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2, 3: exponent = $urandom;
               4: begin
                  case ($urandom_range(0, 2))
                     0: exponent = '0;
                     1: exponent = 32'd1;
                     default: exponent = '1;
                  endcase
               end
               default: exponent = $urandom & ((32'd1 << $urandom_range(1, 12)) - 1);
            endcase
            offer_request(base, exponent, modexp_residue(base, exponent, modulus_setting));
         end
      end

      // Drain, then watch for stray results for about one transaction time.
      req_valid <= 1'b0;
      while (pending_residues.size() != 0) @(posedge clock);
      repeat (END_SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d transactions (%0d from the directed table), %0d residues checked,",
               items_sent, DIRECTED_COUNT, residues_checked);
      $display("under %0d modulus settings including 0, 1, 2 and 2^32-1, with a long output stall.",
               settings_used);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches found", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
